/* design/mhpq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mhpq_pkg;

   localparam int DATA_W  = 32;
   localparam int COUNT_W = 11;
   localparam int POS_W   = COUNT_W + 1;
   localparam int DEPTH   = 1024;
   localparam int ADDR_W  = $clog2(DEPTH);

   localparam logic [COUNT_W-1:0] CAPACITY    = COUNT_W'(DEPTH);
   localparam logic [COUNT_W-1:0] CAP_RESET   = COUNT_W'(1024);

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_REMOVE = 1'b1;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UP,
      ST_DN_LOAD,
      ST_DN
   } state_type;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [DATA_W-1:0] data_type;

   // one-based heap position to store address
   function automatic addr_type pos_to_addr(input logic [POS_W-1:0] p);
      logic [POS_W-1:0] d;
      d = p - POS_W'(1);
      return d[ADDR_W-1:0];
   endfunction

endpackage

`default_nettype wire

/* design/mhpq_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module mhpq_ram
   import mhpq_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     wr_en,
   input  wire addr_type wr_addr,
   input  wire data_type wr_data,
   input  wire addr_type rd_addr_a,
   input  wire addr_type rd_addr_b,
   output logic          [DATA_W-1:0] rd_data_a,
   output logic          [DATA_W-1:0] rd_data_b
);

   data_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

`default_nettype wire

/* design/max_heap_priority_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                                      Handshake
// request   req_kind, req_value                        start & !busy
// response  rsp_removed_value, rsp_status,             rsp_strobe, one cycle
//           rsp_entries_now
// config    csr_write_data                             csr_write_enable
//
// Insert climbs the heap in ST_UP; remove captures the root and the last entry in
// ST_DN_LOAD, then descends in ST_DN. One heap level per cycle, set by the
// store's read latency and single write port.
// Overflow and underflow answer in the cycle after the request is taken.
// The response strobe follows the last busy cycle; the next word may start then.
// Synchronous reset empties the heap and sets the capacity limit to 1024.
// The receiver cannot stall.

module max_heap_priority_queue
   import mhpq_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic                req_kind,
   input  wire logic signed [31:0]  req_value,
   output logic                     rsp_strobe,
   output logic signed [31:0]       rsp_removed_value,
   output logic [1:0]               rsp_status,
   output logic [10:0]              rsp_entries_now,
   input  wire logic                csr_write_enable,
   input  wire logic [10:0]         csr_write_data
);

   state_type           state_ff, state_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [COUNT_W-1:0]  cap_ff, cap_in;
   logic [COUNT_W-1:0]  pos_ff, pos_in;
   data_type            val_ff, val_in;
   data_type            removed_ff, removed_in;
   logic                rsp_strobe_ff, rsp_strobe_in;
   data_type            rsp_removed_ff, rsp_removed_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]  rsp_entries_ff, rsp_entries_in;

   logic                wr_en;
   addr_type            wr_addr, rd_addr_a, rd_addr_b;
   data_type            wr_data, rd_data_a, rd_data_b;

   logic [COUNT_W-1:0]  cap_eff;
   logic [POS_W-1:0]    pos_w, count_w, left_w, right_w, child_w;
   logic                right_ok, l_gt_v, r_gt_l, r_gt_v, go_right, go_left;

   mhpq_ram u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   assign cap_eff  = (cap_ff > CAPACITY) ? CAPACITY : cap_ff;
   assign pos_w    = {1'b0, pos_ff};
   assign count_w  = {1'b0, count_ff};
   assign left_w   = {pos_ff, 1'b0};
   assign right_w  = left_w + POS_W'(1);
   assign right_ok = right_w <= count_w;
   assign l_gt_v   = $signed(rd_data_a) > $signed(val_ff);
   assign r_gt_l   = $signed(rd_data_b) > $signed(rd_data_a);
   assign r_gt_v   = $signed(rd_data_b) > $signed(val_ff);
   assign go_right = right_ok && (l_gt_v ? r_gt_l : r_gt_v);
   assign go_left  = l_gt_v && !go_right;
   assign child_w  = go_right ? right_w : left_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         cap_ff        <= CAP_RESET;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         cap_ff        <= cap_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff         <= pos_in;
      val_ff         <= val_in;
      removed_ff     <= removed_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_entries_ff <= rsp_entries_in;
   end

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      cap_in         = csr_write_enable ? csr_write_data : cap_ff;
      pos_in         = pos_ff;
      val_in         = val_ff;
      removed_in     = removed_ff;
      rsp_strobe_in  = 1'b0;
      rsp_removed_in = rsp_removed_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_entries_in = rsp_entries_ff;
      wr_en          = 1'b0;
      wr_addr        = pos_to_addr(pos_w);
      wr_data        = val_ff;
      rd_addr_a      = '0;
      rd_addr_b      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_kind == KIND_INSERT) begin
                  if (count_ff >= cap_eff) begin
                     rsp_strobe_in  = 1'b1;
                     rsp_removed_in = '0;
                     rsp_status_in  = STATUS_OVERFLOW;
                     rsp_entries_in = count_ff;
                  end else begin
                     count_in  = count_ff + COUNT_W'(1);
                     pos_in    = count_ff + COUNT_W'(1);
                     val_in    = req_value;
                     rd_addr_a = pos_to_addr((count_w + POS_W'(1)) >> 1);
                     state_in  = ST_UP;
                  end
               end else begin
                  if (count_ff == '0) begin
                     rsp_strobe_in  = 1'b1;
                     rsp_removed_in = '0;
                     rsp_status_in  = STATUS_UNDERFLOW;
                     rsp_entries_in = count_ff;
                  end else begin
                     count_in  = count_ff - COUNT_W'(1);
                     rd_addr_a = pos_to_addr(POS_W'(1));
                     rd_addr_b = pos_to_addr(count_w);
                     state_in  = ST_DN_LOAD;
                  end
               end
            end
         end

         ST_UP: begin
            wr_en = 1'b1;
            if (pos_ff != COUNT_W'(1) && $signed(val_ff) > $signed(rd_data_a)) begin
               wr_data   = rd_data_a;
               pos_in    = pos_ff >> 1;
               rd_addr_a = pos_to_addr(pos_w >> 2);
            end else begin
               rsp_strobe_in  = 1'b1;
               rsp_removed_in = '0;
               rsp_status_in  = STATUS_OK;
               rsp_entries_in = count_ff;
               state_in       = ST_IDLE;
            end
         end

         ST_DN_LOAD: begin
            removed_in = rd_data_a;
            val_in     = rd_data_b;
            pos_in     = COUNT_W'(1);
            rd_addr_a  = pos_to_addr(POS_W'(2));
            rd_addr_b  = pos_to_addr(POS_W'(3));
            state_in   = ST_DN;
         end

         ST_DN: begin
            wr_en = 1'b1;
            if (left_w <= count_w && (go_left || go_right)) begin
               wr_data   = go_right ? rd_data_b : rd_data_a;
               pos_in    = child_w[COUNT_W-1:0];
               rd_addr_a = pos_to_addr({child_w[COUNT_W-1:0], 1'b0});
               rd_addr_b = pos_to_addr({child_w[COUNT_W-1:0], 1'b1});
            end else begin
               rsp_strobe_in  = 1'b1;
               rsp_removed_in = removed_ff;
               rsp_status_in  = STATUS_OK;
               rsp_entries_in = count_ff;
               state_in       = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy              = state_ff != ST_IDLE;
   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_removed_value = rsp_removed_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_entries_now   = rsp_entries_ff;

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> state_ff == ST_IDLE)
      else $error("response strobe while busy");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAPACITY)
      else $error("entry count above capacity");

   a_accept_moves: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_strobe_ff))
      else $error("accepted word neither worked nor answered");

   a_up_pos: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_UP |-> (pos_ff != '0 && pos_ff <= count_ff))
      else $error("sift-up position out of range");

   a_dn_pos: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DN |-> (pos_ff <= count_ff || pos_ff == COUNT_W'(1)))
      else $error("sift-down position out of range");

endmodule

`default_nettype wire
